/* src/fps_pkg.sv */
// ----------------------------------------------------------------------------
// fps_pkg
// Shared constants and types of the five-point stencil smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package fps_pkg;

  localparam int unsigned MAX_ROW_LENGTH = 1024;
  localparam int unsigned PIXEL_BITS     = 16;
  localparam int unsigned COL_W          = $clog2(MAX_ROW_LENGTH);
  localparam int unsigned ROW_W          = 16;
  localparam int unsigned COLS_W         = 11;
  localparam int unsigned WEIGHT_W       = 16;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned CFG_IDX_W      = 2;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS_IN_ROW   = 2'd0,
    CFG_ROWS_IN_FRAME    = 2'd1,
    CFG_CENTRE_WEIGHT    = 2'd2,
    CFG_NEIGHBOUR_WEIGHT = 2'd3
  } cfg_idx_e;

  localparam logic [COLS_W-1:0]   COLUMNS_RST   = COLS_W'(1024);
  localparam logic [ROW_W-1:0]    ROWS_RST      = ROW_W'(1024);
  localparam logic [WEIGHT_W-1:0] CENTRE_W_RST  = WEIGHT_W'(39322);
  localparam logic [WEIGHT_W-1:0] NEIGHB_W_RST  = WEIGHT_W'(6554);

endpackage

`default_nettype wire

/* src/fps_stream_if.sv */
// ----------------------------------------------------------------------------
// fps_in_if / fps_out_if
// Valid/ready channels of the stencil smoother: pixel in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fps_in_if;
  logic            valid;
  logic            ready;
  fps_pkg::pixel_t pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface fps_out_if;
  logic            valid;
  logic            ready;
  fps_pkg::pixel_t smoothed_pixel;
  logic            frame_done;

  modport source (output valid, output smoothed_pixel, output frame_done, input ready);
  modport sink   (input valid, input smoothed_pixel, input frame_done, output ready);
endinterface

`default_nettype wire

/* src/five_point_stencil_smoother.sv */
// ----------------------------------------------------------------------------
// five_point_stencil_smoother
// Streams a padded Q8.8 image in raster order and emits the rounded,
// saturated five-point weighted stencil of every interior cell.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  in_i     | in  | valid/ready  | pixel_in
//  out_o    | out | valid/ready  | smoothed_pixel, frame_done
//  cfg      | in  | cfg_we_i     | cfg_idx_i, cfg_wdata_i
//
//  One pixel per cycle while in_i.ready is high. A result passes three registers:
//  operand register, multiply register, round/saturate output register.
//  Line buffer reads are registered and prefetched for the next column.
//  Stages advance independently; a stalled output holds up to three items
//  before in_i.ready drops. Reset clears position, left_q, stage valids and
//  config; line buffers and the other window registers are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module five_point_stencil_smoother (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  fps_in_if.sink                              in_i,
  fps_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [fps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [fps_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned CW = fps_pkg::COL_W;
  localparam int unsigned RW = fps_pkg::ROW_W;
  localparam int unsigned NW = fps_pkg::COLS_W;
  localparam int unsigned PW = fps_pkg::PIXEL_BITS;
  localparam int unsigned WW = fps_pkg::WEIGHT_W;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned PCW = PW + WW;
  localparam int unsigned PNW = SW + WW;
  localparam int unsigned AW = PNW + 1;

  // configuration
  logic [NW-1:0] cols_cfg_q;
  logic [RW-1:0] rows_cfg_q;
  logic [WW-1:0] cw_q, nw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= fps_pkg::COLUMNS_RST;
      rows_cfg_q <= fps_pkg::ROWS_RST;
      cw_q       <= fps_pkg::CENTRE_W_RST;
      nw_q       <= fps_pkg::NEIGHB_W_RST;
    end else if (cfg_we_i) begin
      case (fps_pkg::cfg_idx_e'(cfg_idx_i))
        fps_pkg::CFG_COLUMNS_IN_ROW:   cols_cfg_q <= cfg_wdata_i[NW-1:0];
        fps_pkg::CFG_ROWS_IN_FRAME:    rows_cfg_q <= cfg_wdata_i[RW-1:0];
        fps_pkg::CFG_CENTRE_WEIGHT:    cw_q       <= cfg_wdata_i[WW-1:0];
        fps_pkg::CFG_NEIGHBOUR_WEIGHT: nw_q       <= cfg_wdata_i[WW-1:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] cols_eff;
  logic [RW-1:0] rows_eff;

  always_comb begin
    if (cols_cfg_q < NW'(3))                        cols_eff = NW'(3);
    else if (cols_cfg_q > NW'(fps_pkg::MAX_ROW_LENGTH)) cols_eff = NW'(fps_pkg::MAX_ROW_LENGTH);
    else                                            cols_eff = cols_cfg_q;
    rows_eff = (rows_cfg_q < RW'(3)) ? RW'(3) : rows_cfg_q;
  end

  // pipeline control
  logic s1_v_q, s2_v_q, o_v_q;
  logic out_adv, s2_adv, s1_adv, acc;

  assign out_adv    = !o_v_q || out_o.ready;
  assign s2_adv     = !s2_v_q || out_adv;
  assign s1_adv     = !s1_v_q || s2_adv;
  assign in_i.ready = s1_adv;
  assign acc        = in_i.valid && s1_adv;

  // position
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [NW-1:0] c_ext;
  logic          last_col, last_row, emit, frame_last;

  always_comb begin
    c_ext      = NW'(col_q);
    last_col   = (c_ext + NW'(1)) >= cols_eff;
    last_row   = ({1'b0, row_q} + (RW+1)'(1)) >= {1'b0, rows_eff};
    emit       = (row_q >= RW'(2)) && (col_q != '0) && ((c_ext + NW'(2)) <= cols_eff);
    frame_last = last_row && ((c_ext + NW'(2)) == cols_eff);
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + RW'(1);
    end else begin
      col_d = col_q + CW'(1);
      row_d = row_q;
    end
  end

  // line buffers with prefetched reads
  fps_pkg::pixel_t line_one_mem [fps_pkg::MAX_ROW_LENGTH];
  fps_pkg::pixel_t line_two_mem [fps_pkg::MAX_ROW_LENGTH];
  fps_pkg::pixel_t one_c_q, one_r_q, two_c_q, left_q;
  logic [CW-1:0]   rd_addr, rd_addr_r;

  assign rd_addr   = acc ? col_d : col_q;
  assign rd_addr_r = rd_addr + CW'(1);

  always_ff @(posedge clk_i) begin
    if (acc) begin
      line_one_mem[col_q] <= in_i.pixel_in;
      line_two_mem[col_q] <= one_c_q;
    end
    one_c_q <= line_one_mem[rd_addr];
    one_r_q <= line_one_mem[rd_addr_r];
    two_c_q <= line_two_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (acc) begin
      col_q  <= col_d;
      row_q  <= row_d;
      left_q <= one_c_q;
    end
  end

  // stage 1: operands
  fps_pkg::pixel_t s1_centre_q;
  logic [SW-1:0]   s1_sum_q;
  logic            s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (s1_adv) s1_v_q <= acc && emit;
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_centre_q <= one_c_q;
      s1_sum_q    <= SW'(two_c_q) + SW'(in_i.pixel_in) + SW'(left_q) + SW'(one_r_q);
      s1_last_q   <= frame_last;
    end
  end

  // stage 2: products
  logic [PCW-1:0] s2_pc_q;
  logic [PNW-1:0] s2_pn_q;
  logic           s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (s2_adv) s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_v_q) begin
      s2_pc_q   <= PCW'(s1_centre_q) * PCW'(cw_q);
      s2_pn_q   <= PNW'(s1_sum_q) * PNW'(nw_q);
      s2_last_q <= s1_last_q;
    end
  end

  // stage 3: round, saturate
  logic [AW-1:0]    sum_rnd;
  logic [AW-17:0]   res_wide;
  fps_pkg::pixel_t  res_sat;
  fps_pkg::pixel_t  o_pix_q;
  logic             o_last_q;

  always_comb begin
    sum_rnd  = AW'(s2_pc_q) + AW'(s2_pn_q) + AW'(32768);
    res_wide = sum_rnd[AW-1:16];
    res_sat  = (res_wide > (AW-16)'({PW{1'b1}})) ? {PW{1'b1}} : res_wide[PW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_v_q <= 1'b0;
    else if (out_adv) o_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s2_v_q) begin
      o_pix_q  <= res_sat;
      o_last_q <= s2_last_q;
    end
  end

  assign out_o.valid          = o_v_q;
  assign out_o.smoothed_pixel = o_pix_q;
  assign out_o.frame_done     = o_last_q;

endmodule

`default_nettype wire

/* sim/fps_smoother_checker.sv */
// ----------------------------------------------------------------------------
// fps_smoother_checker
// Watches the pixel, result and register ports of the stencil smoother,
// predicts every result from its own copy of the line buffers and registers,
// and compares each returned result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module fps_smoother_checker import fps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fps_in_if                     pix_mon,
  fps_out_if                    res_mon,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pixel_t value;
    logic   done;
  } smooth_result_t;

  logic [COLS_W-1:0]   cols_cfg;
  logic [ROW_W-1:0]    rows_cfg;
  logic [WEIGHT_W-1:0] centre_w;
  logic [WEIGHT_W-1:0] neighb_w;

  pixel_t         two_up [MAX_ROW_LENGTH];
  pixel_t         one_up [MAX_ROW_LENGTH];
  pixel_t         left_pix;
  int unsigned    col_pos;
  int unsigned    row_pos;
  int unsigned    mismatches;
  smooth_result_t expected_q[$];
  smooth_result_t oldest;

  function automatic void absorb_pixel(input pixel_t pix);
    int unsigned       n_cols;
    int unsigned       n_rows;
    int unsigned       ci;
    longint unsigned   acc;
    longint unsigned   rounded;
    smooth_result_t    res;
    n_cols = int'(cols_cfg);
    if (n_cols < 3) n_cols = 3;
    if (n_cols > MAX_ROW_LENGTH) n_cols = MAX_ROW_LENGTH;
    n_rows = int'(rows_cfg);
    if (n_rows < 3) n_rows = 3;
    ci = col_pos % MAX_ROW_LENGTH;
    if (row_pos >= 2 && col_pos >= 1 && col_pos + 2 <= n_cols) begin
      acc = 64'(one_up[ci]) * 64'(centre_w)
          + (64'(two_up[ci]) + 64'(pix) + 64'(left_pix)
             + 64'(one_up[(ci + 1) % MAX_ROW_LENGTH])) * 64'(neighb_w);
      rounded = (acc + 64'd32768) >> 16;
      res.value = (rounded > 64'({PIXEL_BITS{1'b1}})) ? '1 : pixel_t'(rounded);
      res.done = (row_pos + 1 >= n_rows) && (col_pos + 2 == n_cols);
      expected_q.push_back(res);
    end
    left_pix = one_up[ci];
    two_up[ci] = one_up[ci];
    one_up[ci] = pix;
    if (col_pos + 1 >= n_cols) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= n_rows) ? 0 : ((row_pos + 1) & 32'hFFFF);
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg   = COLUMNS_RST;
      rows_cfg   = ROWS_RST;
      centre_w   = CENTRE_W_RST;
      neighb_w   = NEIGHB_W_RST;
      left_pix   = '0;
      col_pos    = 0;
      row_pos    = 0;
      mismatches = 0;
      expected_q.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h/%b", $time,
                   res_mon.smoothed_pixel, res_mon.frame_done);
          mismatches++;
        end else begin
          oldest = expected_q.pop_front();
          if (res_mon.smoothed_pixel !== oldest.value) begin
            $display("%0t: smoothed_pixel mismatch: expected %h, actual %h", $time,
                     oldest.value, res_mon.smoothed_pixel);
            mismatches++;
          end
          if (res_mon.frame_done !== oldest.done) begin
            $display("%0t: frame_done mismatch: expected %b, actual %b", $time,
                     oldest.done, res_mon.frame_done);
            mismatches++;
          end
        end
      end
      if (pix_mon.valid && pix_mon.ready) absorb_pixel(pix_mon.pixel_in);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COLUMNS_IN_ROW:   cols_cfg = cfg_wdata_i[COLS_W-1:0];
          CFG_ROWS_IN_FRAME:    rows_cfg = cfg_wdata_i[ROW_W-1:0];
          CFG_CENTRE_WEIGHT:    centre_w = cfg_wdata_i[WEIGHT_W-1:0];
          CFG_NEIGHBOUR_WEIGHT: neighb_w = cfg_wdata_i[WEIGHT_W-1:0];
          default: ;
        endcase
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= expected_q.size();
  end

endmodule

/* sim/tb_five_point_stencil_smoother.sv */
// ----------------------------------------------------------------------------
// tb_five_point_stencil_smoother
// Streams padded frames of random and corner-case pixels through the
// smoother under several geometries and weight settings, including width and
// height changes under the cursor, with random source gaps, sink stalls and a
// long sink hold-off; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_five_point_stencil_smoother;
  timeunit 1ns;
  timeprecision 1ps;
  import fps_pkg::*;

  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned FLUSH_CYCLES = 8;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fps_in_if  pix_if ();
  fps_out_if res_if ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  int unsigned eff_cols       = MAX_ROW_LENGTH;
  int unsigned eff_rows       = 1024;
  int unsigned next_col       = 0;
  int unsigned next_row       = 0;
  int unsigned pixels_sent    = 0;
  int unsigned quiet_cycles   = 0;

  always #5 clk_i = ~clk_i;

  five_point_stencil_smoother dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (pix_if),
    .out_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  fps_smoother_checker stencil_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pix_mon          (pix_if),
    .res_mon          (res_if),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  // sink side: random stalls, plus one long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      res_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic pixel_t random_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight(input bit low_range);
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return low_range ? WEIGHT_W'($urandom_range(16383)) : WEIGHT_W'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input pixel_t pix);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid = 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid    = 1'b1;
    pix_if.pixel_in = pix;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    if (next_col + 1 >= eff_cols) begin
      next_col = 0;
      next_row = (next_row + 1 >= eff_rows) ? 0 : next_row + 1;
    end else begin
      next_col = next_col + 1;
    end
    pixels_sent++;
    @(negedge clk_i);
  endtask

  // sends until the cursor is back at the top left corner
  task automatic stream_frame();
    do send_pixel(random_pixel());
    while (next_col != 0 || next_row != 0);
  endtask

  task automatic settle();
    pix_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (FLUSH_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] cols_word,
                              input logic [CFG_DATA_W-1:0] rows_word);
    write_reg(CFG_COLUMNS_IN_ROW, cols_word);
    write_reg(CFG_ROWS_IN_FRAME, rows_word);
    eff_cols = int'(cols_word[COLS_W-1:0]);
    if (eff_cols < 3) eff_cols = 3;
    if (eff_cols > MAX_ROW_LENGTH) eff_cols = MAX_ROW_LENGTH;
    eff_rows = int'(rows_word);
    if (eff_rows < 3) eff_rows = 3;
  endtask

  task automatic randomize_config();
    logic [CFG_DATA_W-1:0] cols_word;
    logic [CFG_DATA_W-1:0] rows_word;
    cols_word = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(2))
                                         : CFG_DATA_W'($urandom_range(14, 3));
    cols_word[CFG_DATA_W-1:COLS_W] = (CFG_DATA_W-COLS_W)'($urandom);
    rows_word = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(2))
                                         : CFG_DATA_W'($urandom_range(7, 3));
    set_geometry(cols_word, rows_word);
    write_reg(CFG_CENTRE_WEIGHT, pick_weight(1'b0));
    write_reg(CFG_NEIGHBOUR_WEIGHT, pick_weight(1'b1));
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned target);
    int unsigned start;
    start          = pixels_sent;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (pixels_sent - start < target) begin
      randomize_config();
      stream_frame();
      settle();
    end
  endtask

  initial begin
    pixel_t rounding_frame [12];
    rounding_frame = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                       16'h5A5A, 16'h8000, 16'h7FFF, 16'hA5A5,
                       16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
    pix_if.valid    = 1'b0;
    pix_if.pixel_in = '0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_COLUMNS_IN_ROW;
    cfg_wdata       = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // smallest frame, reset weights, all-ones pixels: result saturates
    set_geometry(16'd1, 16'd2);
    repeat (9) send_pixel('1);
    settle();

    // round half up: centre 0x8000 gives 1, centre 0x7FFF gives 0
    write_reg(CFG_CENTRE_WEIGHT, 16'd1);
    write_reg(CFG_NEIGHBOUR_WEIGHT, 16'd0);
    set_geometry(16'd4, 16'd3);
    foreach (rounding_frame[i]) send_pixel(rounding_frame[i]);
    settle();

    run_phase(0, 0, 160);

    // one full-width row, then the row length shrinks under the cursor
    write_reg(CFG_CENTRE_WEIGHT, CENTRE_W_RST);
    write_reg(CFG_NEIGHBOUR_WEIGHT, NEIGHB_W_RST);
    set_geometry(16'hFFFF, 16'd3);
    repeat (MAX_ROW_LENGTH + 6) send_pixel(random_pixel());
    settle();
    set_geometry(16'd6, 16'd3);
    stream_frame();
    settle();

    run_phase(83, 0, 160);

    // sink holds off while the source keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 83;
    set_geometry(16'd12, 16'd6);
    hold_req = 1'b1;
    stream_frame();
    settle();
    run_phase(0, 83, 160);

    // tallest frame height set mid-frame, then cut below the cursor
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    set_geometry(16'd5, 16'd4);
    repeat (13) send_pixel(random_pixel());
    settle();
    set_geometry(16'd5, 16'hFFFF);
    repeat (25) send_pixel(random_pixel());
    settle();
    set_geometry(16'd5, 16'd3);
    stream_frame();
    settle();
    run_phase(12, 12, 200);

    settle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
src/fps_pkg.sv
src/fps_stream_if.sv
src/five_point_stencil_smoother.sv
sim/fps_smoother_checker.sv
sim/tb_five_point_stencil_smoother.sv
